>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define AST_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Clocked assertion on the block clock and reset.
`define AST_CHK(lbl, prop) \
    `AST_CLK(lbl, i_clk, i_rst_n, prop)

`endif

>>> sv/xcfr_pkg.sv
`timescale 1ns / 1ps

package xcfr_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam int IDX_POS       = 2;
    localparam int DUTY_HI_POS   = 3;
    localparam int DUTY_LO_POS   = 4;
    localparam int FREQ_HI_POS   = 5;
    localparam int FREQ_LO_POS   = 6;
    localparam int KEY_POS       = 6;

    typedef enum logic [1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_KEY_CODE      = 2'd2,
        CFG_BEEP_CODE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_BEEP  = 2'd1,
        KIND_OTHER = 2'd2
    } t_frame_kind;

    localparam logic [7:0] BEEP_CODE_RESET = 8'h04;

    localparam logic [7:0] KEY_NONE       = 8'h00;
    localparam logic [7:0] KEY_PRESS_LO   = 8'h01;
    localparam logic [7:0] KEY_PRESS_HI   = 8'h06;
    localparam logic [7:0] KEY_RELEASE_LO = 8'h0A;
    localparam logic [7:0] KEY_RELEASE_HI = 8'h0F;

    localparam logic signed [3:0] KEY_UNKNOWN = 4'sb1111;

endpackage

>>> sv/xor_checked_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Frame receiver with two-byte header sync and XOR check.
// Input channel: i_rx_valid / o_rx_ready carry one received byte per request.
// Output channel: o_res_valid / i_res_ready carry one decoded frame per request:
// kind, index byte, key report fields and beep state fields.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (header bytes, key report code, beep state code), used from the next cycle on.
// Throughput: one byte per cycle while o_rx_ready is high. Each byte is
// appended, and on a full window the header search, XOR check and decode
// all complete in that same cycle, and the frame is output in the next cycle.
// Stall: bytes that cannot complete a window are taken even while a frame
// waits in the output register; the byte that would fill the window waits
// until the output register is free or is being emptied.
// Reset: window emptied, output invalid, headers and key code 0, beep code 4.
module xor_checked_frame_receiver_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [1:0]          o_frame_kind,
    output logic [7:0]          o_index_byte,
    output logic [7:0]          o_key_raw,
    output logic signed [3:0]   o_key_number,
    output logic                o_key_down,
    output logic [15:0]         o_beep_duty,
    output logic [15:0]         o_beep_frequency
);

    localparam int F = xcfr_pkg::FRAME_BYTES;

    logic [7:0] r_hdr_first;
    logic [7:0] r_hdr_second;
    logic [7:0] r_key_code;
    logic [7:0] r_beep_code;

    logic [7:0]                  r_win [F];
    logic [7:0]                  n_win [F];
    logic [xcfr_pkg::FILL_W-1:0] r_fill;
    logic [xcfr_pkg::FILL_W-1:0] n_fill;

    logic [7:0]                  w [F];
    logic [7:0]                  shifted [F];
    logic                        last_byte;
    logic                        accept;
    logic                        found;
    logic [xcfr_pkg::POS_W-1:0]  pos;
    logic [xcfr_pkg::POS_W-1:0]  sh;
    logic [7:0]                  sum;
    logic                        emit;

    logic                        r_res_valid;
    logic [1:0]                  r_kind;
    logic [7:0]                  r_index;
    logic [7:0]                  r_key_raw;
    logic signed [3:0]           r_key_num;
    logic                        r_key_down;
    logic [15:0]                 r_duty;
    logic [15:0]                 r_freq;

    logic [1:0]                  n_kind;
    logic [7:0]                  n_key_raw;
    logic signed [3:0]           n_key_num;
    logic                        n_key_down;
    logic [15:0]                 n_duty;
    logic [15:0]                 n_freq;

    assign last_byte  = (r_fill == xcfr_pkg::FILL_W'(F - 1));
    assign o_rx_ready = !last_byte || !r_res_valid || i_res_ready;
    assign accept     = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= '0;
            r_hdr_second <= '0;
            r_key_code   <= '0;
            r_beep_code  <= xcfr_pkg::BEEP_CODE_RESET;
        end else if (i_cfg_we) begin
            unique case (xcfr_pkg::t_cfg_idx'(i_cfg_idx))
                xcfr_pkg::CFG_HEADER_FIRST:  r_hdr_first  <= i_cfg_data;
                xcfr_pkg::CFG_HEADER_SECOND: r_hdr_second <= i_cfg_data;
                xcfr_pkg::CFG_KEY_CODE:      r_key_code   <= i_cfg_data;
                xcfr_pkg::CFG_BEEP_CODE:     r_beep_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // append, search, check, realign
    always_comb begin
        for (int j = 0; j < F; j++) begin
            w[j] = (r_fill[xcfr_pkg::POS_W-1:0] == xcfr_pkg::POS_W'(j)) ? i_rx_byte : r_win[j];
        end

        found = 1'b0;
        pos   = '0;
        for (int i = F - 2; i >= 0; i--) begin
            if (w[i] == r_hdr_first && w[i + 1] == r_hdr_second) begin
                found = 1'b1;
                pos   = xcfr_pkg::POS_W'(i);
            end
        end

        sum = '0;
        for (int i = 0; i < F - 1; i++) begin
            sum = sum ^ w[i];
        end

        sh = (pos == '0) ? xcfr_pkg::POS_W'(1) : pos;
        for (int j = 0; j < F; j++) begin
            shifted[j] = w[j];
            for (int k = 1; k < F; k++) begin
                if (sh == xcfr_pkg::POS_W'(k) && j + k < F) begin
                    shifted[j] = w[j + k];
                end
            end
        end

        emit   = 1'b0;
        n_win  = r_win;
        n_fill = r_fill;
        if (accept) begin
            if (!last_byte) begin
                n_win  = w;
                n_fill = r_fill + xcfr_pkg::FILL_W'(1);
            end else if (!found) begin
                n_fill = '0;
            end else if (pos != '0 || sum != w[F - 1]) begin
                n_win  = shifted;
                n_fill = xcfr_pkg::FILL_W'(F) - xcfr_pkg::FILL_W'(sh);
            end else begin
                emit   = 1'b1;
                n_fill = '0;
            end
        end
    end

    // decode
    always_comb begin
        logic [7:0] raw;
        raw        = w[xcfr_pkg::KEY_POS];
        n_kind     = xcfr_pkg::KIND_OTHER;
        n_key_raw  = '0;
        n_key_num  = '0;
        n_key_down = 1'b0;
        n_duty     = '0;
        n_freq     = '0;
        if (w[xcfr_pkg::IDX_POS] == r_key_code) begin
            n_kind    = xcfr_pkg::KIND_KEY;
            n_key_raw = raw;
            if (raw >= xcfr_pkg::KEY_PRESS_LO && raw <= xcfr_pkg::KEY_PRESS_HI) begin
                n_key_num  = 4'(raw - xcfr_pkg::KEY_PRESS_LO);
                n_key_down = 1'b1;
            end else if (raw >= xcfr_pkg::KEY_RELEASE_LO && raw <= xcfr_pkg::KEY_RELEASE_HI) begin
                n_key_num  = 4'(raw - xcfr_pkg::KEY_RELEASE_LO);
                n_key_down = 1'b0;
            end else begin
                n_key_num  = xcfr_pkg::KEY_UNKNOWN;
                n_key_down = (raw > xcfr_pkg::KEY_NONE) && (raw < xcfr_pkg::KEY_RELEASE_LO);
            end
        end else if (w[xcfr_pkg::IDX_POS] == r_beep_code) begin
            n_kind = xcfr_pkg::KIND_BEEP;
            n_duty = {w[xcfr_pkg::DUTY_HI_POS], w[xcfr_pkg::DUTY_LO_POS]};
            n_freq = {w[xcfr_pkg::FREQ_HI_POS], w[xcfr_pkg::FREQ_LO_POS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (emit) begin
            r_kind     <= n_kind;
            r_index    <= w[xcfr_pkg::IDX_POS];
            r_key_raw  <= n_key_raw;
            r_key_num  <= n_key_num;
            r_key_down <= n_key_down;
            r_duty     <= n_duty;
            r_freq     <= n_freq;
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_frame_kind     = r_kind;
    assign o_index_byte     = r_index;
    assign o_key_raw        = r_key_raw;
    assign o_key_number     = r_key_num;
    assign o_key_down       = r_key_down;
    assign o_beep_duty      = r_duty;
    assign o_beep_frequency = r_freq;

endmodule

>>> sv/xcfr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xcfr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_res_valid,
    input logic                i_res_ready,
    input logic [1:0]          o_frame_kind,
    input logic [7:0]          o_index_byte,
    input logic [7:0]          o_key_raw,
    input logic signed [3:0]   o_key_number,
    input logic                o_key_down,
    input logic [15:0]         o_beep_duty,
    input logic [15:0]         o_beep_frequency
);

    logic [54:0] res_payload;
    logic        key_fields_zero;
    logic        beep_fields_zero;
    logic        known_key;
    logic        press_code;

    assign res_payload      = {o_frame_kind, o_index_byte, o_key_raw, o_key_number,
                               o_key_down, o_beep_duty, o_beep_frequency};
    assign key_fields_zero  = (o_key_raw == 8'h00) && (o_key_number == 4'sb0000)
                              && !o_key_down;
    assign beep_fields_zero = (o_beep_duty == 16'h0000) && (o_beep_frequency == 16'h0000);
    assign known_key        = (o_frame_kind == xcfr_pkg::KIND_KEY)
                              && (o_key_number != xcfr_pkg::KEY_UNKNOWN);
    assign press_code       = (o_key_raw <= xcfr_pkg::KEY_PRESS_HI);

    `AST_CHK(a_res_hold, o_res_valid && !i_res_ready |=> o_res_valid && $stable(res_payload))

    `AST_CHK(a_key_clear, o_res_valid && o_frame_kind != xcfr_pkg::KIND_KEY |-> key_fields_zero)

    `AST_CHK(a_beep_clear, o_res_valid && o_frame_kind != xcfr_pkg::KIND_BEEP |-> beep_fields_zero)

    `AST_CHK(a_key_press, o_res_valid && known_key |-> o_key_down == press_code)

endmodule

bind xor_checked_frame_receiver_unit xcfr_checker u_xcfr_checker (.*);

>>> sim/xor_checked_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps

module xor_checked_frame_receiver_unit_tb;

    localparam int CLK_PERIOD    = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 640;

    typedef logic [7:0] t_frame_bytes [xcfr_pkg::FRAME_BYTES];

    typedef struct {
        xcfr_pkg::t_frame_kind kind;
        logic [7:0]            index_byte;
        logic [7:0]            key_raw;
        logic signed [3:0]     key_number;
        logic                  key_down;
        logic [15:0]           duty;
        logic [15:0]           frequency;
    } t_decoded_frame;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_idx   = '0;
    logic [7:0]        cfg_data  = '0;
    logic              rx_valid  = 1'b0;
    logic              rx_ready;
    logic [7:0]        rx_byte   = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    logic [1:0]        frame_kind;
    logic [7:0]        index_byte;
    logic [7:0]        key_raw;
    logic signed [3:0] key_number;
    logic              key_down;
    logic [15:0]       beep_duty;
    logic [15:0]       beep_frequency;

    // Receive window and registers as the block should hold them
    logic [7:0] rx_win [xcfr_pkg::FRAME_BYTES];
    int         rx_count  = 0;
    logic [7:0] hdr_first  = 8'h00;
    logic [7:0] hdr_second = 8'h00;
    logic [7:0] key_code   = 8'h00;
    logic [7:0] beep_code  = xcfr_pkg::BEEP_CODE_RESET;

    t_decoded_frame pending_frames[$];

    int errors         = 0;
    int bytes_sent     = 0;
    int frames_seen    = 0;
    int settings_used  = 1;
    int kind_count [3] = '{0, 0, 0};
    int cycle_count    = 0;
    bit gaps_on        = 1'b0;
    bit stalls_on      = 1'b0;
    bit hold_req       = 1'b0;

    xor_checked_frame_receiver_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_rx_valid       (rx_valid),
        .o_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_frame_kind     (frame_kind),
        .o_index_byte     (index_byte),
        .o_key_raw        (key_raw),
        .o_key_number     (key_number),
        .o_key_down       (key_down),
        .o_beep_duty      (beep_duty),
        .o_beep_frequency (beep_frequency)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void drop_front(input int count);
        for (int i = 0; i < rx_count - count; i++) rx_win[i] = rx_win[i + count];
        rx_count -= count;
    endfunction

    function automatic bit absorb_byte(input logic [7:0] b, output t_decoded_frame f);
        int         pos;
        bit         found;
        logic [7:0] sum;
        logic [7:0] raw;
        f.kind       = xcfr_pkg::KIND_OTHER;
        f.index_byte = '0;
        f.key_raw    = '0;
        f.key_number = '0;
        f.key_down   = 1'b0;
        f.duty       = '0;
        f.frequency  = '0;
        if (rx_count < xcfr_pkg::FRAME_BYTES) begin
            rx_win[rx_count] = b;
            rx_count++;
        end
        if (rx_count < xcfr_pkg::FRAME_BYTES) return 1'b0;
        found = 1'b0;
        pos   = 0;
        for (int i = 0; i + 1 < rx_count; i++) begin
            if (!found && rx_win[i] == hdr_first && rx_win[i + 1] == hdr_second) begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (!found) begin
            rx_count = 0;
            return 1'b0;
        end
        if (pos != 0) begin
            drop_front(pos);
            return 1'b0;
        end
        sum = '0;
        for (int i = 0; i < xcfr_pkg::FRAME_BYTES - 1; i++) sum ^= rx_win[i];
        if (sum != rx_win[xcfr_pkg::FRAME_BYTES - 1]) begin
            drop_front(1);
            return 1'b0;
        end
        f.index_byte = rx_win[xcfr_pkg::IDX_POS];
        if (rx_win[xcfr_pkg::IDX_POS] == key_code) begin
            raw       = rx_win[xcfr_pkg::KEY_POS];
            f.kind    = xcfr_pkg::KIND_KEY;
            f.key_raw = raw;
            if (raw >= xcfr_pkg::KEY_PRESS_LO && raw <= xcfr_pkg::KEY_PRESS_HI) begin
                f.key_number = 4'(raw - xcfr_pkg::KEY_PRESS_LO);
                f.key_down   = 1'b1;
            end else if (raw >= xcfr_pkg::KEY_RELEASE_LO && raw <= xcfr_pkg::KEY_RELEASE_HI) begin
                f.key_number = 4'(raw - xcfr_pkg::KEY_RELEASE_LO);
                f.key_down   = 1'b0;
            end else begin
                f.key_number = xcfr_pkg::KEY_UNKNOWN;
                f.key_down   = (raw > xcfr_pkg::KEY_NONE && raw < xcfr_pkg::KEY_RELEASE_LO);
            end
        end else if (rx_win[xcfr_pkg::IDX_POS] == beep_code) begin
            f.kind      = xcfr_pkg::KIND_BEEP;
            f.duty      = {rx_win[xcfr_pkg::DUTY_HI_POS], rx_win[xcfr_pkg::DUTY_LO_POS]};
            f.frequency = {rx_win[xcfr_pkg::FREQ_HI_POS], rx_win[xcfr_pkg::FREQ_LO_POS]};
        end
        rx_count = 0;
        return 1'b1;
    endfunction

    function automatic t_frame_bytes make_frame(input logic [7:0] idx, d3, d4, d5, d6);
        t_frame_bytes f;
        f[0]                         = hdr_first;
        f[1]                         = hdr_second;
        f[xcfr_pkg::IDX_POS]         = idx;
        f[xcfr_pkg::DUTY_HI_POS]     = d3;
        f[xcfr_pkg::DUTY_LO_POS]     = d4;
        f[xcfr_pkg::FREQ_HI_POS]     = d5;
        f[xcfr_pkg::FREQ_LO_POS]     = d6;
        f[xcfr_pkg::FRAME_BYTES - 1] = '0;
        for (int i = 0; i < xcfr_pkg::FRAME_BYTES - 1; i++)
            f[xcfr_pkg::FRAME_BYTES - 1] ^= f[i];
        return f;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                          input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int             gap;
        t_decoded_frame f;
        gap = pick_gap();
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        bytes_sent++;
        if (absorb_byte(b, f)) pending_frames.push_back(f);
    endtask

    task automatic send_frame(input t_frame_bytes f);
        for (int i = 0; i < xcfr_pkg::FRAME_BYTES; i++) send_byte(f[i]);
    endtask

    task automatic drain();
        rx_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input xcfr_pkg::t_cfg_idx idx, input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            xcfr_pkg::CFG_HEADER_FIRST:  hdr_first  = v;
            xcfr_pkg::CFG_HEADER_SECOND: hdr_second = v;
            xcfr_pkg::CFG_KEY_CODE:      key_code   = v;
            xcfr_pkg::CFG_BEEP_CODE:     beep_code  = v;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] h1, h2, k, bc);
        drain();
        write_reg(xcfr_pkg::CFG_HEADER_FIRST, h1);
        write_reg(xcfr_pkg::CFG_HEADER_SECOND, h2);
        write_reg(xcfr_pkg::CFG_KEY_CODE, k);
        write_reg(xcfr_pkg::CFG_BEEP_CODE, bc);
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_frame(make_frame(xcfr_pkg::BEEP_CODE_RESET, 8'h12, 8'h34, 8'h56, 8'h78));
        send_frame(make_frame(8'h00, 8'h00, 8'h00, 8'h00, xcfr_pkg::KEY_PRESS_HI));
    endtask

    task automatic test_key_reports();
        apply_setting(8'hA5, 8'h5A, 8'h01, 8'h02);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_frame(make_frame(8'h01, 8'h00, 8'h00, 8'h00, xcfr_pkg::KEY_PRESS_LO));
        send_frame(make_frame(8'h01, 8'hFF, 8'hFF, 8'hFF, xcfr_pkg::KEY_RELEASE_HI));
        send_frame(make_frame(8'h01, 8'h10, 8'h20, 8'h30, 8'h09));
        send_frame(make_frame(8'h01, 8'h40, 8'h50, 8'h60, 8'hFF));
    endtask

    task automatic test_beep_and_other();
        send_frame(make_frame(8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_frame(make_frame(8'h80, 8'h01, 8'h02, 8'h03, 8'h04));
    endtask

    task automatic test_equal_codes();
        apply_setting(8'hA5, 8'h5A, 8'h33, 8'h33);
        send_frame(make_frame(8'h33, 8'hAA, 8'hBB, 8'hCC, xcfr_pkg::KEY_RELEASE_LO));
    endtask

    task automatic test_sync_recovery();
        t_frame_bytes f;
        f = make_frame(8'h33, 8'h11, 8'h22, 8'h33, 8'h44);
        f[xcfr_pkg::FRAME_BYTES - 1] ^= 8'h01;
        send_frame(f);
        send_frame(make_frame(8'h33, 8'h00, 8'h00, 8'h00, xcfr_pkg::KEY_PRESS_LO));
        // header late in the window: drop the leading junk
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_frame(make_frame(8'h33, 8'h01, 8'h01, 8'h01, 8'h03));
        // no full header: lone first header byte at the tail goes too
        repeat (xcfr_pkg::FRAME_BYTES - 1) send_byte(8'hC3);
        send_byte(hdr_first);
        send_frame(make_frame(8'h33, 8'h02, 8'h02, 8'h02, 8'h05));
    endtask

    task automatic test_output_backpressure();
        drain();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < 6; i++)
            send_frame(make_frame(8'h33, 8'($urandom), 8'($urandom), 8'($urandom), 8'(i)));
    endtask

    task automatic test_pause_drain();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (3) send_frame(make_frame(8'h33, 8'($urandom), 8'h00, 8'hFF, 8'h02));
        drain();
        repeat (3) send_frame(make_frame(8'h44, 8'($urandom), 8'hFF, 8'h00, 8'h0B));
    endtask

    task automatic send_random_unit();
        t_frame_bytes f;
        logic [7:0]   idx;
        logic [7:0]   raw;
        int           r;
        int           pos;
        r         = $urandom_range(0, 99);
        gaps_on   = ($urandom_range(0, 4) != 0);
        stalls_on = ($urandom_range(0, 4) != 0);
        if (r < 12) begin
            repeat ($urandom_range(1, 10))
                send_byte(($urandom_range(0, 3) == 0) ? hdr_first : 8'($urandom));
            return;
        end
        case ($urandom_range(0, 2))
            0:       idx = key_code;
            1:       idx = beep_code;
            default: idx = 8'($urandom);
        endcase
        raw = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
        f   = make_frame(idx, 8'($urandom), 8'($urandom), 8'($urandom), raw);
        if (r < 24) begin
            pos = $urandom_range(0, xcfr_pkg::FRAME_BYTES - 1);
            f[pos] ^= 8'(1 << $urandom_range(0, 7));
        end else if (r < 32) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
        send_frame(f);
    endtask

    task automatic test_random_traffic();
        int phase_end;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       apply_setting(8'hA5, 8'h5A, 8'h01, 8'h02);
                1:       apply_setting(8'hFF, 8'hFF, 8'hFF, 8'h00);
                2:       apply_setting(8'h00, 8'h00, 8'h80, 8'h80);
                default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            phase_end = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < phase_end) send_random_unit();
        end
    endtask

    initial begin : result_sink
        int             stall_left;
        int             r;
        t_decoded_frame exp_f;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready) begin
                if (pending_frames.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, got kind %h index %h",
                             $time, frame_kind, index_byte);
                    errors++;
                end else begin
                    exp_f = pending_frames.pop_front();
                    frames_seen++;
                    kind_count[exp_f.kind]++;
                    compare_field("frame_kind", 16'(exp_f.kind), 16'(frame_kind));
                    compare_field("index_byte", 16'(exp_f.index_byte), 16'(index_byte));
                    compare_field("key_raw", 16'(exp_f.key_raw), 16'(key_raw));
                    compare_field("key_number", 16'(exp_f.key_number), 16'(key_number));
                    compare_field("key_down", 16'(exp_f.key_down), 16'(key_down));
                    compare_field("beep_duty", exp_f.duty, beep_duty);
                    compare_field("beep_frequency", exp_f.frequency, beep_frequency);
                end
            end
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && stalls_on) begin
                r = $urandom_range(0, 99);
                if (r >= 92) stall_left = $urandom_range(10, 40);
                else if (r >= 70) stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                res_ready <= 1'b0;
                stall_left--;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_key_reports();
        test_beep_and_other();
        test_equal_codes();
        test_sync_recovery();
        test_output_backpressure();
        test_pause_drain();
        test_random_traffic();
        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes under %0d register settings, with a long output hold-off",
                 bytes_sent, settings_used);
        $display("Checked %0d frames: %0d key reports, %0d beep states, %0d other",
                 frames_seen, kind_count[xcfr_pkg::KIND_KEY], kind_count[xcfr_pkg::KIND_BEEP],
                 kind_count[xcfr_pkg::KIND_OTHER]);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
